>>> rtl/core/ckh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_pkg
// Shared types, constants and controller/datapath signal groups for the
// two-hash cuckoo table with overflow stash.
// ----------------------------------------------------------------------------
package ckh_pkg;

    // default sizes of the stores
    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int MAX_BINS_DEF    = 4096;
    localparam int STASH_DEPTH_DEF = 64;

    // fixed field widths
    localparam int HASH_W      = 64;
    localparam int ITEM_W      = 10;
    localparam int BIN_CNT_W   = 13;
    localparam int STASH_CNT_W = 7;
    localparam int TRY_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // remainder unit: bits retired per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = HASH_W / MOD_BITS;

    typedef logic [HASH_W-1:0]      t_hash;
    typedef logic [ITEM_W-1:0]      t_item_idx;
    typedef logic [BIN_CNT_W-1:0]   t_bin_count;
    typedef logic [STASH_CNT_W-1:0] t_stash_cnt;
    typedef logic [TRY_W-1:0]       t_try;

    // register reset values
    localparam t_bin_count BIN_COUNT_RST = t_bin_count'(4096);
    localparam t_stash_cnt STASH_RST     = t_stash_cnt'(8);
    localparam t_try       TRY_RST       = t_try'(100);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_COUNT    = 2'd0,
        CFG_STASH_IN_USE = 2'd1,
        CFG_TRY_LIMIT    = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_FIND   = 1'b1
    } t_req;

    // dividend source for the remainder unit
    typedef enum logic [1:0] {
        MOD_H0   = 2'd1,
        MOD_H1   = 2'd2,
        MOD_HV   = 2'd3
    } t_mod_src;

    typedef enum logic [1:0] {
        PH_BIN0  = 2'd0,
        PH_BIN1  = 2'd1,
        PH_STASH = 2'd2
    } t_find_phase;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_I_CHK,
        S_I_TEST,
        S_I_MOD,
        S_I_BRD,
        S_I_BUPD,
        S_I_HRD,
        S_I_HMOD,
        S_I_STASH,
        S_F_MOD,
        S_F_BRD,
        S_F_BCHK,
        S_F_HRD,
        S_F_HCMP,
        S_F_SCHK,
        S_F_SRD,
        S_DONE
    } t_ckh_state;

    // controller to datapath
    typedef struct packed {
        logic     clr_we;
        logic     load_in;
        logic     mod_start;
        t_mod_src mod_src;
        logic     cur_from_item;
        logic     addr_from_mod;
        logic     ins_mark;
        logic     bin_write;
        logic     evict;
        logic     evict_last;
        logic     stash_push;
        logic     cur_from_bin;
        logic     cur_from_stash;
        logic     scan_clr;
        logic     scan_inc;
        logic     res_set;
        t_status  res_code;
        logic     res_idx;
        logic     res_stash;
        logic     out_load;
    } t_ckh_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic req_find;
        logic mod_done;
        logic used_hit;
        logic bin_valid;
        logic tries_left;
        logic stash_full;
        logic scan_end;
        logic hash_match;
        logic out_busy;
    } t_ckh_stat;

endpackage

>>> rtl/core/cuckoo_hash_table_with_stash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_hash_table_with_stash
// Two-hash cuckoo table of item indices with an overflow stash.
// ----------------------------------------------------------------------------
// One request is handled at a time; a finished result sits in an output
// register, so the next request is taken while it waits. Bin addresses come
// from a shared remainder unit that retires 4 hash bits a cycle. After the
// accepting cycle, an insert takes and checks the index, places the item in
// its first bin, re-places each evicted item in its other bin, pushes the
// last one to the stash once the eviction limit is reached, and hands the
// result over. A find probes the first bin and, on a miss, the second,
// compares the stored hashes for each probe that hits an occupied bin, then
// scans the filled stash slots before handing its result over. After reset a
// clearing pass over the first max(MAX_BINS, MAX_ITEMS) addresses empties the
// bin table and the used flags; no request is accepted during it, while
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_with_stash #(
    parameter int MAX_ITEMS   = ckh_pkg::MAX_ITEMS_DEF,
    parameter int MAX_BINS    = ckh_pkg::MAX_BINS_DEF,
    parameter int STASH_DEPTH = ckh_pkg::STASH_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ckh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // requests
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [ckh_pkg::ITEM_W-1:0]      i_item_index,
    input  logic [ckh_pkg::HASH_W-1:0]      i_hash_first,
    input  logic [ckh_pkg::HASH_W-1:0]      i_hash_second,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ckh_pkg::STATUS_W-1:0]    o_status,
    output logic [ckh_pkg::ITEM_W-1:0]      o_found_index,
    output logic                            o_went_to_stash
);

    ckh_pkg::t_ckh_cmd  cmd;
    ckh_pkg::t_ckh_stat stat;

    // registers are written whenever a transaction with a defined index arrives
    assign o_cfg_ready = 1'b1;

    ckh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ckh_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .MAX_BINS    (MAX_BINS),
        .STASH_DEPTH (STASH_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_item_index    (i_item_index),
        .i_hash_first    (i_hash_first),
        .i_hash_second   (i_hash_second),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_found_index   (o_found_index),
        .o_went_to_stash (o_went_to_stash),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

endmodule

>>> rtl/core/ckh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ckh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ckh_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_mod
// Iterative remainder of a 64-bit value by a narrow divisor, a few
// dividend bits per cycle (restoring scheme).
// ----------------------------------------------------------------------------
module ckh_mod #(
    parameter int DW = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ckh_pkg::t_hash        i_dividend,
    input  logic [DW-1:0]         i_divisor,
    output logic                  o_done,
    output logic [DW-1:0]         o_rem
);

    localparam int STW = (ckh_pkg::MOD_STEPS > 2) ? $clog2(ckh_pkg::MOD_STEPS) : 1;

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [STW-1:0] r_step, n_step;
    ckh_pkg::t_hash r_dvd, n_dvd;
    logic [DW-1:0]  r_rem, n_rem;
    logic [DW-1:0]  r_div, n_div;

    // one step: retire MOD_BITS dividend bits
    always_comb begin
        logic [DW:0]    v_trial;
        logic [DW-1:0]  v_rem;
        ckh_pkg::t_hash v_dvd;
        v_trial = '0;
        v_rem   = r_rem;
        v_dvd   = r_dvd;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_div  = i_divisor;
            v_rem  = '0;
            v_dvd  = i_dividend;
        end else if (r_busy) begin
            for (int k = 0; k < ckh_pkg::MOD_BITS; k++) begin
                v_trial = {v_rem, v_dvd[ckh_pkg::HASH_W-1]};
                v_dvd   = {v_dvd[ckh_pkg::HASH_W-2:0], 1'b0};
                if (v_trial >= {1'b0, r_div}) begin
                    v_trial = v_trial - {1'b0, r_div};
                end
                v_rem = v_trial[DW-1:0];
            end
            n_step = r_step + STW'(1);
            if (r_step == STW'(ckh_pkg::MOD_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        n_rem = v_rem;
        n_dvd = v_dvd;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/ckh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_datapath
// Stores, configuration, request and result registers of the cuckoo table;
// acts on commands from the controller and reports status back.
// ----------------------------------------------------------------------------
module ckh_datapath #(
    parameter int MAX_ITEMS   = ckh_pkg::MAX_ITEMS_DEF,
    parameter int MAX_BINS    = ckh_pkg::MAX_BINS_DEF,
    parameter int STASH_DEPTH = ckh_pkg::STASH_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    input  logic [ckh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request payload
    input  logic                            i_req_type,
    input  ckh_pkg::t_item_idx              i_item_index,
    input  ckh_pkg::t_hash                  i_hash_first,
    input  ckh_pkg::t_hash                  i_hash_second,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ckh_pkg::STATUS_W-1:0]    o_status,
    output ckh_pkg::t_item_idx              o_found_index,
    output logic                            o_went_to_stash,
    // controller
    input  ckh_pkg::t_ckh_cmd               i_cmd,
    output ckh_pkg::t_ckh_stat              o_stat
);

    localparam int IW    = $clog2(MAX_ITEMS);
    localparam int AW    = $clog2(MAX_BINS);
    localparam int MAXN  = (MAX_BINS > MAX_ITEMS) ? MAX_BINS : MAX_ITEMS;
    localparam int DW    = $clog2(MAXN + 1);
    localparam int EW    = (DW > ckh_pkg::BIN_CNT_W) ? DW : ckh_pkg::BIN_CNT_W;
    localparam int SW    = (STASH_DEPTH > 2) ? $clog2(STASH_DEPTH) : 1;
    localparam int SDEP  = 1 << SW;
    localparam int CNTW  = $clog2(STASH_DEPTH + 1);
    localparam int BEW   = IW + 2;
    localparam int CLRW  = $clog2(MAXN);

    // configuration registers
    ckh_pkg::t_bin_count r_bin_count;
    ckh_pkg::t_stash_cnt r_stash_in_use;
    ckh_pkg::t_try       r_try_limit;

    // request and working registers
    logic                r_req;
    ckh_pkg::t_item_idx  r_item;
    ckh_pkg::t_hash      r_h0, r_h1;
    logic [IW-1:0]       r_cur;
    logic                r_hsel;
    ckh_pkg::t_try       r_tries;
    logic [AW-1:0]       r_addr;
    logic [CNTW-1:0]     r_scan;
    logic [SW-1:0]       r_base;
    logic [CNTW-1:0]     r_cnt;
    logic [CLRW-1:0]     r_clr;

    // pending and delivered result
    ckh_pkg::t_status    r_res_status;
    logic [IW-1:0]       r_res_idx;
    logic                r_res_stash;
    logic                r_out_valid;
    ckh_pkg::t_status    r_out_status;
    logic [IW-1:0]       r_out_idx;
    logic                r_out_stash;

    // memory ports
    logic                bin_we;
    logic [AW-1:0]       bin_waddr;
    logic [BEW-1:0]      bin_wdata, bin_rdata;
    logic                stash_we;
    logic [SW-1:0]       stash_waddr, stash_raddr;
    logic [BEW-1:0]      stash_rdata;
    ckh_pkg::t_hash      ha_rdata, hb_rdata;
    logic                used_we;
    logic [IW-1:0]       used_waddr;
    logic [0:0]          used_wdata, used_rdata;

    // remainder unit
    ckh_pkg::t_hash      mod_dividend;
    logic [DW-1:0]       mod_divisor;
    logic                mod_done;
    logic [DW-1:0]       mod_rem;

    // effective sizes
    logic [EW-1:0]       w_bc, w_nb;
    ckh_pkg::t_stash_cnt w_ns, w_cnt, w_lim;
    logic                bin_clr, used_clr;

    always_comb begin
        w_bc  = EW'(r_bin_count);
        if (w_bc == '0) begin
            w_nb = EW'(1);
        end else if (w_bc > EW'(MAX_BINS)) begin
            w_nb = EW'(MAX_BINS);
        end else begin
            w_nb = w_bc;
        end
        w_ns  = (r_stash_in_use > ckh_pkg::t_stash_cnt'(STASH_DEPTH))
              ? ckh_pkg::t_stash_cnt'(STASH_DEPTH) : r_stash_in_use;
        w_cnt = ckh_pkg::t_stash_cnt'(r_cnt);
        w_lim = (w_cnt < w_ns) ? w_cnt : w_ns;
    end

    // clearing pass ranges
    assign bin_clr  = i_cmd.clr_we && ({1'b0, r_clr} < (CLRW + 1)'(MAX_BINS));
    assign used_clr = i_cmd.clr_we && ({1'b0, r_clr} < (CLRW + 1)'(MAX_ITEMS));

    // bin table port selection
    always_comb begin
        bin_we    = bin_clr || i_cmd.bin_write;
        bin_waddr = bin_clr ? r_clr[AW-1:0] : r_addr;
        bin_wdata = bin_clr ? '0 : {1'b1, r_hsel, r_cur};
    end

    // stash is a ring: logical slot i sits at base + i
    assign stash_we    = i_cmd.stash_push;
    assign stash_waddr = r_base - SW'(1);
    assign stash_raddr = r_base + r_scan[SW-1:0];

    // used flags
    always_comb begin
        used_we    = used_clr || i_cmd.ins_mark;
        used_waddr = used_clr ? r_clr[IW-1:0] : r_cur;
        used_wdata = used_clr ? 1'b0 : 1'b1;
    end

    // remainder operand selection
    always_comb begin
        case (i_cmd.mod_src)
            ckh_pkg::MOD_H0:   mod_dividend = r_h0;
            ckh_pkg::MOD_H1:   mod_dividend = r_h1;
            ckh_pkg::MOD_HV:   mod_dividend = r_hsel ? hb_rdata : ha_rdata;
            default:           mod_dividend = r_h0;
        endcase
        mod_divisor = DW'(w_nb);
    end

    ckh_mod #(.DW(DW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    ckh_ram #(.WIDTH(BEW), .DEPTH(MAX_BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (r_addr),
        .o_rdata (bin_rdata)
    );

    ckh_ram #(.WIDTH(BEW), .DEPTH(SDEP)) u_stash_ram (
        .i_clk   (i_clk),
        .i_we    (stash_we),
        .i_waddr (stash_waddr),
        .i_wdata ({1'b1, r_hsel, r_cur}),
        .i_raddr (stash_raddr),
        .o_rdata (stash_rdata)
    );

    ckh_ram #(.WIDTH(ckh_pkg::HASH_W), .DEPTH(MAX_ITEMS)) u_hash_a_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_mark),
        .i_waddr (r_cur),
        .i_wdata (r_h0),
        .i_raddr (r_cur),
        .o_rdata (ha_rdata)
    );

    ckh_ram #(.WIDTH(ckh_pkg::HASH_W), .DEPTH(MAX_ITEMS)) u_hash_b_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_mark),
        .i_waddr (r_cur),
        .i_wdata (r_h1),
        .i_raddr (r_cur),
        .o_rdata (hb_rdata)
    );

    ckh_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (r_cur),
        .o_rdata (used_rdata)
    );

    // configuration writes, clear counter, stash ring, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count    <= ckh_pkg::BIN_COUNT_RST;
            r_stash_in_use <= ckh_pkg::STASH_RST;
            r_try_limit    <= ckh_pkg::TRY_RST;
            r_clr          <= '0;
            r_base         <= '0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == ckh_pkg::CFG_BIN_COUNT) begin
                    r_bin_count <= ckh_pkg::t_bin_count'(i_cfg_data);
                end else if (i_cfg_index == ckh_pkg::CFG_STASH_IN_USE) begin
                    r_stash_in_use <= ckh_pkg::t_stash_cnt'(i_cfg_data);
                end else if (i_cfg_index == ckh_pkg::CFG_TRY_LIMIT) begin
                    r_try_limit <= ckh_pkg::t_try'(i_cfg_data);
                end
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + CLRW'(1);
            end
            if (i_cmd.stash_push) begin
                r_base <= r_base - SW'(1);
                r_cnt  <= r_cnt + CNTW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req  <= i_req_type;
            r_item <= i_item_index;
            r_h0   <= i_hash_first;
            r_h1   <= i_hash_second;
        end
        // index wraps at the power-of-two table size by truncation
        if (i_cmd.cur_from_item) begin
            r_cur <= IW'(r_item);
        end else if (i_cmd.evict || i_cmd.evict_last || i_cmd.cur_from_bin) begin
            r_cur <= bin_rdata[IW-1:0];
        end else if (i_cmd.cur_from_stash) begin
            r_cur <= stash_rdata[IW-1:0];
        end
        if (i_cmd.addr_from_mod) begin
            r_addr <= mod_rem[AW-1:0];
        end
        if (i_cmd.ins_mark) begin
            r_hsel  <= 1'b0;
            r_tries <= '0;
        end else if (i_cmd.evict) begin
            r_hsel  <= ~bin_rdata[IW];
            r_tries <= r_tries + ckh_pkg::t_try'(1);
        end else if (i_cmd.evict_last) begin
            r_hsel  <= bin_rdata[IW];
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + CNTW'(1);
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_idx    <= i_cmd.res_idx ? r_cur : '0;
            r_res_stash  <= i_cmd.res_stash;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_stash  <= r_res_stash;
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.clr_last   = (r_clr == CLRW'(MAXN - 1));
        o_stat.req_find   = (r_req == ckh_pkg::REQ_FIND);
        o_stat.mod_done   = mod_done;
        o_stat.used_hit   = used_rdata[0];
        o_stat.bin_valid  = bin_rdata[IW+1];
        o_stat.tries_left = (r_tries < r_try_limit);
        o_stat.stash_full = (w_cnt >= w_ns);
        o_stat.scan_end   = (ckh_pkg::t_stash_cnt'(r_scan) >= w_lim);
        o_stat.hash_match = (ha_rdata == r_h0) && (hb_rdata == r_h1);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found_index   = ckh_pkg::t_item_idx'(r_out_idx);
    assign o_went_to_stash = r_out_stash;

endmodule

>>> rtl/core/ckh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_ctrl
// Sequencer for the cuckoo table: clearing pass, insert eviction walk,
// find over both bins and the stash, and result hand-off.
// ----------------------------------------------------------------------------
module ckh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ckh_pkg::t_ckh_stat  i_stat,
    output ckh_pkg::t_ckh_cmd   o_cmd
);

    ckh_pkg::t_ckh_state  r_state, n_state;
    ckh_pkg::t_find_phase r_fph, n_fph;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ckh_pkg::S_CLEAR;
            r_fph   <= ckh_pkg::PH_BIN0;
        end else begin
            r_state <= n_state;
            r_fph   <= n_fph;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_fph      = r_fph;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ckh_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ckh_pkg::S_IDLE;
                end
            end
            ckh_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ckh_pkg::S_START;
                end
            end
            ckh_pkg::S_START: begin
                if (i_stat.req_find) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_src   = ckh_pkg::MOD_H0;
                    n_fph           = ckh_pkg::PH_BIN0;
                    n_state         = ckh_pkg::S_F_MOD;
                end else begin
                    o_cmd.cur_from_item = 1'b1;
                    n_state             = ckh_pkg::S_I_CHK;
                end
            end
            // insert: check the index is free
            ckh_pkg::S_I_CHK: begin
                n_state = ckh_pkg::S_I_TEST;
            end
            ckh_pkg::S_I_TEST: begin
                if (i_stat.used_hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ckh_pkg::ST_DUPLICATE;
                    n_state        = ckh_pkg::S_DONE;
                end else begin
                    o_cmd.ins_mark  = 1'b1;
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_src   = ckh_pkg::MOD_H0;
                    n_state         = ckh_pkg::S_I_MOD;
                end
            end
            // insert: eviction walk
            ckh_pkg::S_I_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.addr_from_mod = 1'b1;
                    n_state             = ckh_pkg::S_I_BRD;
                end
            end
            ckh_pkg::S_I_BRD: begin
                n_state = ckh_pkg::S_I_BUPD;
            end
            ckh_pkg::S_I_BUPD: begin
                o_cmd.bin_write = 1'b1;
                if (!i_stat.bin_valid) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ckh_pkg::ST_INSERTED;
                    n_state        = ckh_pkg::S_DONE;
                end else if (i_stat.tries_left) begin
                    o_cmd.evict = 1'b1;
                    n_state     = ckh_pkg::S_I_HRD;
                end else begin
                    o_cmd.evict_last = 1'b1;
                    n_state          = ckh_pkg::S_I_STASH;
                end
            end
            ckh_pkg::S_I_HRD: begin
                n_state = ckh_pkg::S_I_HMOD;
            end
            ckh_pkg::S_I_HMOD: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_src   = ckh_pkg::MOD_HV;
                n_state         = ckh_pkg::S_I_MOD;
            end
            // homeless item goes to the front of the stash, or overflows if it is full
            ckh_pkg::S_I_STASH: begin
                o_cmd.res_set = 1'b1;
                if (i_stat.stash_full) begin
                    o_cmd.res_code = ckh_pkg::ST_OVERFLOW;
                end else begin
                    o_cmd.stash_push = 1'b1;
                    o_cmd.res_code   = ckh_pkg::ST_INSERTED;
                    o_cmd.res_stash  = 1'b1;
                end
                n_state = ckh_pkg::S_DONE;
            end
            // find: candidate bins
            ckh_pkg::S_F_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.addr_from_mod = 1'b1;
                    n_state             = ckh_pkg::S_F_BRD;
                end
            end
            ckh_pkg::S_F_BRD: begin
                n_state = ckh_pkg::S_F_BCHK;
            end
            ckh_pkg::S_F_BCHK: begin
                if (i_stat.bin_valid) begin
                    o_cmd.cur_from_bin = 1'b1;
                    n_state            = ckh_pkg::S_F_HRD;
                end else if (r_fph == ckh_pkg::PH_BIN0) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_src   = ckh_pkg::MOD_H1;
                    n_fph           = ckh_pkg::PH_BIN1;
                    n_state         = ckh_pkg::S_F_MOD;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_fph          = ckh_pkg::PH_STASH;
                    n_state        = ckh_pkg::S_F_SCHK;
                end
            end
            ckh_pkg::S_F_HRD: begin
                n_state = ckh_pkg::S_F_HCMP;
            end
            ckh_pkg::S_F_HCMP: begin
                if (i_stat.hash_match) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ckh_pkg::ST_FOUND;
                    o_cmd.res_idx  = 1'b1;
                    n_state        = ckh_pkg::S_DONE;
                end else if (r_fph == ckh_pkg::PH_BIN0) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_src   = ckh_pkg::MOD_H1;
                    n_fph           = ckh_pkg::PH_BIN1;
                    n_state         = ckh_pkg::S_F_MOD;
                end else if (r_fph == ckh_pkg::PH_BIN1) begin
                    o_cmd.scan_clr = 1'b1;
                    n_fph          = ckh_pkg::PH_STASH;
                    n_state        = ckh_pkg::S_F_SCHK;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ckh_pkg::S_F_SCHK;
                end
            end
            // find: filled prefix of the stash
            ckh_pkg::S_F_SCHK: begin
                if (i_stat.scan_end) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ckh_pkg::ST_NOT_FOUND;
                    n_state        = ckh_pkg::S_DONE;
                end else begin
                    n_state = ckh_pkg::S_F_SRD;
                end
            end
            ckh_pkg::S_F_SRD: begin
                o_cmd.cur_from_stash = 1'b1;
                n_state              = ckh_pkg::S_F_HRD;
            end
            // hand the result to the output register
            ckh_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ckh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ckh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cuckoo table with stash against a cycle-free table model kept in
// the bench: inserts, finds, evictions, stash pushes, overflow and duplicates,
// across several table, stash and eviction-limit settings with random stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NBINS   = ckh_pkg::MAX_BINS_DEF;
    localparam int NSTASH  = ckh_pkg::STASH_DEPTH_DEF;
    localparam int NITEMS  = ckh_pkg::MAX_ITEMS_DEF;
    localparam int LIMIT   = 20_000_000;

    typedef struct {
        ckh_pkg::t_req      req;
        ckh_pkg::t_item_idx idx;
        ckh_pkg::t_hash     h0;
        ckh_pkg::t_hash     h1;
    } t_request;

    typedef struct {
        ckh_pkg::t_status   status;
        ckh_pkg::t_item_idx idx;
        logic               stashed;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [ckh_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ckh_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic i_req_type = 1'b0;
    ckh_pkg::t_item_idx i_item_index = '0;
    ckh_pkg::t_hash i_hash_first = '0;
    ckh_pkg::t_hash i_hash_second = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_went_to_stash;
    logic [ckh_pkg::STATUS_W-1:0] o_status;
    ckh_pkg::t_item_idx o_found_index;

    cuckoo_hash_table_with_stash dut (.*);

    always #2 i_clk = ~i_clk;

    // mirror of the table contents
    logic               bin_v [NBINS];
    logic               bin_sel [NBINS];
    ckh_pkg::t_item_idx bin_idx [NBINS];
    logic               stash_v [NSTASH];
    logic               stash_sel [NSTASH];
    ckh_pkg::t_item_idx stash_idx [NSTASH];
    ckh_pkg::t_hash     mem_a [NITEMS];
    ckh_pkg::t_hash     mem_b [NITEMS];
    logic               idx_taken [NITEMS];
    int unsigned bins_reg = 4096, stash_reg = 8, tries_reg = 100;

    t_request  pending_reqs [$];
    t_answer   expected_answers [$];
    t_request  known_items [$];
    bit        idx_issued [NITEMS];

    int  fails = 0;
    int  cycles = 0;
    int  idle_mode = 0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    bit  in_took = 1'b0;

    function automatic bit hit(logic v, ckh_pkg::t_item_idx i, ckh_pkg::t_hash h0,
                               ckh_pkg::t_hash h1);
        return v && mem_a[i] == h0 && mem_b[i] == h1;
    endfunction

    // work out the answer to one accepted request and update the mirror
    function automatic t_answer table_lookup_update(t_request r);
        t_answer a;
        longint unsigned nb, ns, hv, tries, free_slot;
        ckh_pkg::t_item_idx cur, old_idx;
        logic h, old_v, old_sel;
        int b;
        a = '{ckh_pkg::ST_INSERTED, '0, 1'b0};
        nb = bins_reg == 0 ? 1 : (bins_reg > NBINS ? NBINS : bins_reg);
        ns = stash_reg > NSTASH ? NSTASH : stash_reg;
        if (r.req == ckh_pkg::REQ_FIND) begin
            b = int'(r.h0 % nb);
            if (hit(bin_v[b], bin_idx[b], r.h0, r.h1))
                return '{ckh_pkg::ST_FOUND, bin_idx[b], 1'b0};
            b = int'(r.h1 % nb);
            if (hit(bin_v[b], bin_idx[b], r.h0, r.h1))
                return '{ckh_pkg::ST_FOUND, bin_idx[b], 1'b0};
            for (int i = 0; i < ns && stash_v[i]; i++)
                if (hit(1'b1, stash_idx[i], r.h0, r.h1))
                    return '{ckh_pkg::ST_FOUND, stash_idx[i], 1'b0};
            return '{ckh_pkg::ST_NOT_FOUND, '0, 1'b0};
        end
        cur = r.idx;
        if (idx_taken[cur]) return '{ckh_pkg::ST_DUPLICATE, '0, 1'b0};
        idx_taken[cur] = 1'b1;
        mem_a[cur] = r.h0;
        mem_b[cur] = r.h1;
        h = 1'b0;
        tries = 0;
        // eviction chain
        forever begin
            hv = h ? mem_b[cur] : mem_a[cur];
            b = int'(hv % nb);
            old_v = bin_v[b];
            old_sel = bin_sel[b];
            old_idx = bin_idx[b];
            bin_v[b] = 1'b1;
            bin_sel[b] = h;
            bin_idx[b] = cur;
            if (!old_v) return a;
            cur = old_idx;
            if (tries < tries_reg) begin
                tries++;
                h = ~old_sel;
            end else begin
                h = old_sel;
                break;
            end
        end
        // homeless item goes to the head of the stash
        free_slot = ns;
        for (int i = 0; i < ns; i++)
            if (!stash_v[i]) begin
                free_slot = i;
                break;
            end
        if (free_slot >= ns) return '{ckh_pkg::ST_OVERFLOW, '0, 1'b0};
        for (int i = int'(free_slot); i > 0; i--) begin
            stash_v[i] = stash_v[i-1];
            stash_sel[i] = stash_sel[i-1];
            stash_idx[i] = stash_idx[i-1];
        end
        stash_v[0] = 1'b1;
        stash_sel[0] = h;
        stash_idx[0] = cur;
        a.stashed = 1'b1;
        return a;
    endfunction

    function automatic ckh_pkg::t_hash rand_hash();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_insert(ckh_pkg::t_item_idx i, ckh_pkg::t_hash h0,
                                ckh_pkg::t_hash h1);
        t_request r;
        r = '{ckh_pkg::REQ_INSERT, i, h0, h1};
        pending_reqs.push_back(r);
        if (!idx_issued[i]) known_items.push_back(r);
        idx_issued[i] = 1'b1;
    endtask

    task automatic queue_find(ckh_pkg::t_hash h0, ckh_pkg::t_hash h1);
        pending_reqs.push_back('{ckh_pkg::REQ_FIND, ckh_pkg::t_item_idx'($urandom), h0, h1});
    endtask

    // one random request: mostly fresh inserts and finds of known items
    task automatic queue_random();
        int sel, k;
        ckh_pkg::t_item_idx i;
        sel = $urandom_range(99);
        if (sel < 40 || known_items.size() == 0) begin
            i = ckh_pkg::t_item_idx'($urandom);
            k = 0;
            while (idx_issued[i] && k < 50 && $urandom_range(9) != 0) begin
                i = ckh_pkg::t_item_idx'($urandom);
                k++;
            end
            queue_insert(i, rand_hash(), rand_hash());
        end else if (sel < 75) begin
            k = $urandom_range(known_items.size() - 1);
            queue_find(known_items[k].h0, known_items[k].h1);
        end else if (sel < 90) begin
            queue_find(rand_hash(), rand_hash());
        end else begin
            k = $urandom_range(known_items.size() - 1);
            queue_find(known_items[k].h0, rand_hash());
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || expected_answers.size() != 0 || i_in_valid);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(ckh_pkg::t_cfg_idx idx, int unsigned data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= ckh_pkg::CFG_DATA_W'(data);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned bc, int unsigned sc, int unsigned tl, int n);
        cfg_write(ckh_pkg::CFG_BIN_COUNT, bc);
        cfg_write(ckh_pkg::CFG_STASH_IN_USE, sc);
        cfg_write(ckh_pkg::CFG_TRY_LIMIT, tl);
        repeat (n) queue_random();
        wait_drained();
    endtask

    // mirror config write at the accepting edge
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            case (ckh_pkg::t_cfg_idx'(i_cfg_index))
                ckh_pkg::CFG_BIN_COUNT:    bins_reg = i_cfg_data;
                ckh_pkg::CFG_STASH_IN_USE: stash_reg = i_cfg_data[ckh_pkg::STASH_CNT_W-1:0];
                ckh_pkg::CFG_TRY_LIMIT:    tries_reg = i_cfg_data[ckh_pkg::TRY_W-1:0];
                default: ;
            endcase
        end
    end

    // request acceptance and prediction
    always @(posedge i_clk) begin
        t_request r;
        in_took = 1'b0;
        if (i_in_valid && o_in_ready) begin
            r = '{ckh_pkg::t_req'(i_req_type), i_item_index, i_hash_first, i_hash_second};
            expected_answers.push_back(table_lookup_update(r));
            in_took = 1'b1;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_request r;
        bit idle;
        if (!i_in_valid || in_took) begin
            case (idle_mode)
                0: idle = $urandom_range(99) < 36;
                1: idle = $urandom_range(99) < 84;
                default: idle = 1'b0;
            endcase
            if (pending_reqs.size() != 0 && !idle && i_rst_n) begin
                r = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= r.req;
                i_item_index <= r.idx;
                i_hash_first <= r.h0;
                i_hash_second <= r.h1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with a long hold when asked
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                0: i_out_ready <= $urandom_range(99) >= 84;
                1: i_out_ready <= $urandom_range(99) >= 36;
                default: i_out_ready <= 1'b1;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer e;
        if (o_out_valid && i_out_ready) begin
            if (expected_answers.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                fails++;
            end else begin
                e = expected_answers.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    fails++;
                end
                if (o_found_index !== e.idx) begin
                    $error("found_index: expected %0d, got %0d", e.idx, o_found_index);
                    fails++;
                end
                if (o_went_to_stash !== e.stashed) begin
                    $error("went_to_stash: expected %0d, got %0d", e.stashed,
                           o_went_to_stash);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NBINS; i++) begin
            bin_v[i] = 1'b0;
            bin_sel[i] = 1'b0;
            bin_idx[i] = '0;
        end
        for (int i = 0; i < NSTASH; i++) begin
            stash_v[i] = 1'b0;
            stash_sel[i] = 1'b0;
            stash_idx[i] = '0;
        end
        for (int i = 0; i < NITEMS; i++) begin
            mem_a[i] = '0;
            mem_b[i] = '0;
            idx_taken[i] = 1'b0;
            idx_issued[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, eviction, duplicates, misses, equal hashes
        queue_insert(10'd0, 64'd0, '1);
        queue_insert(10'd1023, '1, 64'd0);
        queue_insert(10'd5, 64'd0, 64'h0123_4567_89ab_cdef);
        queue_insert(10'd7, 64'h5555_aaaa_5555_aaaa, 64'h5555_aaaa_5555_aaaa);
        queue_insert(10'd0, 64'd3, 64'd4);
        queue_find(64'd0, '1);
        queue_find('1, 64'd0);
        queue_find(64'd0, 64'h0123_4567_89ab_cdef);
        queue_find(64'h5555_aaaa_5555_aaaa, 64'h5555_aaaa_5555_aaaa);
        queue_find(64'd0, 64'd0);
        queue_find('1, '1);
        queue_find(64'd0, 64'd1);
        queue_find(64'haaaa_5555_aaaa_5555, 64'h1);
        wait_drained();

        // one bin, no stash: every collision overflows
        run_phase(0, 0, 3, 20);
        // one bin, two stash slots
        run_phase(1, 2, 1, 15);
        // over-range bin count and stash size, eviction limit of zero
        run_phase(8191, 8191, 0, 150);

        idle_mode = 1;
        // few bins and the longest eviction chains
        run_phase(16, 64, 255, 30);
        // busy table with back-pressure stretch
        cfg_write(ckh_pkg::CFG_BIN_COUNT, 64);
        cfg_write(ckh_pkg::CFG_STASH_IN_USE, 8);
        cfg_write(ckh_pkg::CFG_TRY_LIMIT, 4);
        hold_req = 1'b1;
        repeat (400) queue_random();
        wait_drained();

        idle_mode = 2;
        run_phase(1000, 16, 20, 420);

        if (fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
